>>> hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared types and constants for the RC4 controller and datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam logic       OP_KEY  = 1'b0;
  localparam logic       OP_DATA = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_KEY   = 2'd1;
  localparam logic [1:0] STAT_KEY_LONG = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_ACC,
    ST_KS_WA,
    ST_KS_WK,
    ST_GEN_RI,
    ST_GEN_RJ,
    ST_GEN_WJ,
    ST_GEN_WI,
    ST_GEN_OUT
  } state_t;

  typedef struct packed {
    logic key_wr;
    logic bypass;
    logic cap;
    logic sched_start;
    logic fill;
    logic ks_rd;
    logic ks_acc;
    logic ks_wa;
    logic ks_wk;
    logic sched_done;
    logic gen_ri;
    logic gen_rj;
    logic gen_wj;
    logic gen_wi;
    logic gen_out;
  } dp_cmd_t;

  typedef struct packed {
    logic keyed;
    logic k_last;
  } dp_sts_t;

endpackage

>>> hw/rtl/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences the identity fill, key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_opcode,
  input  logic             in_is_last,
  input  rc4_pkg::dp_sts_t sts,
  output rc4_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import rc4_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.fill = 1'b1;
        if (sts.k_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_KEY: begin
              cmd.key_wr = 1'b1;
              if (in_is_last) begin
                cmd.sched_start = 1'b1;
                state_nxt       = ST_FILL;
              end
            end
            OP_DATA: begin
              if (sts.keyed) begin
                cmd.cap   = 1'b1;
                state_nxt = ST_GEN_RI;
              end else begin
                cmd.bypass = 1'b1;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.k_last) state_nxt = ST_KS_RD;
      end
      ST_KS_RD: begin
        cmd.ks_rd = 1'b1;
        state_nxt = ST_KS_ACC;
      end
      ST_KS_ACC: begin
        cmd.ks_acc = 1'b1;
        state_nxt  = ST_KS_WA;
      end
      ST_KS_WA: begin
        cmd.ks_wa = 1'b1;
        state_nxt = ST_KS_WK;
      end
      ST_KS_WK: begin
        cmd.ks_wk = 1'b1;
        if (sts.k_last) begin
          cmd.sched_done = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_GEN_RI: begin
        cmd.gen_ri = 1'b1;
        state_nxt  = ST_GEN_RJ;
      end
      ST_GEN_RJ: begin
        cmd.gen_rj = 1'b1;
        state_nxt  = ST_GEN_WJ;
      end
      ST_GEN_WJ: begin
        cmd.gen_wj = 1'b1;
        state_nxt  = ST_GEN_WI;
      end
      ST_GEN_WI: begin
        cmd.gen_wi = 1'b1;
        state_nxt  = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        cmd.gen_out = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> hw/rtl/rc4_datapath.sv
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key memories, indices, key gathering and result register.
// ----------------------------------------------------------------------------
module rc4_datapath #(
  parameter int KEY_MAX = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rc4_pkg::dp_cmd_t cmd,
  output rc4_pkg::dp_sts_t sts,
  input  logic [7:0]       in_byte_in,
  input  logic             in_is_last,
  output logic             out_strobe,
  output logic [7:0]       out_byte_out,
  output logic             out_out_last,
  output logic [1:0]       out_status
);
  import rc4_pkg::*;

  localparam logic [8:0] KeyLimit = 9'(KEY_MAX);

  logic [7:0] perm_mem [256];
  logic [7:0] key_mem  [256];

  logic [7:0] k_r, i_r, j_r, acc_r, kp_r;
  logic [8:0] key_count_r;
  logic       keyed_r, ovf_r;
  logic [7:0] byte_r, si_r, sk_r;
  logic       last_r, hit_r;
  logic [7:0] ra_r, rb_r, kd_r;
  logic       strobe_r, olast_r;
  logic [7:0] obyte_r;
  logic [1:0] ostat_r;

  logic       wr_en;
  logic [7:0] wr_addr, wr_data;
  logic [7:0] ra_addr, rb_addr;
  logic       rb_en;
  logic [7:0] acc_nxt, j_nxt, t_addr;
  logic [8:0] sched_len, kp_inc;

  assign acc_nxt   = acc_r + ra_r + kd_r;
  assign j_nxt     = j_r + ra_r;
  assign t_addr    = si_r + rb_r;
  assign sched_len = (key_count_r == 9'd0) ? 9'd1 : key_count_r;
  assign kp_inc    = {1'b0, kp_r} + 9'd1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_r;
    wr_data = k_r;
    ra_addr = k_r;
    rb_addr = acc_nxt;
    rb_en   = 1'b0;
    if (cmd.fill) begin
      wr_en = 1'b1;
    end
    if (cmd.ks_wa) begin
      wr_en   = 1'b1;
      wr_addr = acc_r;
      wr_data = sk_r;
    end
    if (cmd.ks_wk) begin
      wr_en   = 1'b1;
      wr_data = rb_r;
    end
    if (cmd.gen_wj) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = si_r;
    end
    if (cmd.gen_wi) begin
      wr_en   = 1'b1;
      wr_addr = i_r;
      wr_data = rb_r;
      ra_addr = t_addr;
    end
    if (cmd.gen_ri) ra_addr = i_r + 8'd1;
    if (cmd.ks_acc) rb_en = 1'b1;
    if (cmd.gen_rj) begin
      rb_en   = 1'b1;
      rb_addr = j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) perm_mem[wr_addr] <= wr_data;
    ra_r <= perm_mem[ra_addr];
    if (rb_en) rb_r <= perm_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr && (key_count_r < KeyLimit)) key_mem[key_count_r[7:0]] <= in_byte_in;
    kd_r <= key_mem[kp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
      keyed_r     <= 1'b0;
      ovf_r       <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cmd.key_wr) begin
        if (key_count_r < KeyLimit) key_count_r <= key_count_r + 9'd1;
        else ovf_r <= 1'b1;
      end
      if (cmd.fill || cmd.ks_wk) k_r <= k_r + 8'd1;
      if (cmd.sched_done) begin
        key_count_r <= '0;
        keyed_r     <= 1'b1;
        ovf_r       <= 1'b0;
        i_r         <= '0;
        j_r         <= '0;
        strobe_r    <= ovf_r;
      end
      if (cmd.gen_ri) i_r <= i_r + 8'd1;
      if (cmd.gen_rj) j_r <= j_nxt;
      if (cmd.bypass || cmd.gen_out) strobe_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_start) begin
      acc_r <= '0;
      kp_r  <= '0;
    end
    if (cmd.ks_acc) begin
      acc_r <= acc_nxt;
      sk_r  <= ra_r;
    end
    if (cmd.ks_wk) kp_r <= (kp_inc == sched_len) ? 8'd0 : kp_inc[7:0];
    if (cmd.cap) begin
      byte_r <= in_byte_in;
      last_r <= in_is_last;
    end
    if (cmd.gen_rj) si_r <= ra_r;
    if (cmd.gen_wi) hit_r <= (t_addr == i_r);
    if (cmd.sched_done) begin
      obyte_r <= '0;
      olast_r <= 1'b0;
      ostat_r <= STAT_KEY_LONG;
    end
    if (cmd.bypass) begin
      obyte_r <= in_byte_in;
      olast_r <= in_is_last;
      ostat_r <= STAT_NO_KEY;
    end
    if (cmd.gen_out) begin
      obyte_r <= byte_r ^ (hit_r ? rb_r : ra_r);
      olast_r <= last_r;
      ostat_r <= STAT_OK;
    end
  end

  assign sts.keyed  = keyed_r;
  assign sts.k_last = (k_r == 8'd255);

  assign out_strobe   = strobe_r;
  assign out_byte_out = obyte_r;
  assign out_out_last = olast_r;
  assign out_status   = ostat_r;

endmodule

>>> hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key bytes are taken while idle; the last one refills the permutation with identity,
// then reads, accumulates and swap-writes each entry. Data bytes: busy until the result
// strobe, set by the single-write permutation memory; bypassed bytes strobe next cycle.
// Reset: busy for 256 cycles while the permutation is filled with identity.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_opcode,
  input  logic [7:0] in_byte_in,
  input  logic       in_is_last,
  output logic       out_strobe,
  output logic [7:0] out_byte_out,
  output logic       out_out_last,
  output logic [1:0] out_status
);
  import rc4_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_opcode  (in_opcode),
    .in_is_last (in_is_last),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  rc4_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte_in   (in_byte_in),
    .in_is_last   (in_is_last),
    .out_strobe   (out_strobe),
    .out_byte_out (out_byte_out),
    .out_out_last (out_out_last),
    .out_status   (out_status)
  );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives key and data beats through the start/busy port and scores every
// strobed result against an in-bench RC4 cipher model. A short table of
// directed beats comes first: data before any key, a known key, the keystream
// running on past the end of a message, and key bytes mixed in between data.
// Random messages follow, with keys of 1..16 bytes, exactly KEY_MAX bytes and
// over-long keys, plus a share of unformed noise beats. Sender gaps are
// random, and a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb;
  import rc4_pkg::*;

  localparam int KEY_MAX  = 256;
  localparam int ITEMS    = 1550;
  localparam int WATCHDOG = 8000;
  localparam int N_ROWS   = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } cipher_beat_t;

  typedef struct packed {
    logic         op;
    logic [7:0]   b;
    logic         last;
    logic         typed;
    cipher_beat_t want;
  } stim_row_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       start        = 1'b0;
  logic       in_opcode    = OP_KEY;
  logic [7:0] in_byte_in   = 8'h00;
  logic       in_is_last   = 1'b0;
  logic       busy;
  logic       out_strobe;
  logic [7:0] out_byte_out;
  logic       out_out_last;
  logic [1:0] out_status;

  // cipher model state
  logic [7:0]  sbox    [256];
  logic [7:0]  key_mem [256];
  int unsigned key_len;
  logic [7:0]  idx_i, idx_j;
  bit          have_key, key_dropped;

  cipher_beat_t cipher_q [$];
  int fail_n, accepted_n, dropped_n, results_n, schedules_n, long_keys_n;
  int idle_cycles;

  stim_row_t dir_rows [N_ROWS] = '{
    '{OP_DATA, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, STAT_NO_KEY}},
    '{OP_DATA, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, STAT_NO_KEY}},
    '{OP_KEY,  8'h4B, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h65, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h79, 1'b1, 1'b0, '0},
    '{OP_DATA, 8'h50, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h6C, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h61, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h69, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h6E, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h74, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h65, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h78, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'h74, 1'b1, 1'b0, '0},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'hFF, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'hFF, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h00, 1'b1, 1'b0, '0},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, '0},
    '{OP_DATA, 8'hFF, 1'b1, 1'b0, '0},
    '{OP_KEY,  8'hFF, 1'b1, 1'b0, '0},
    '{OP_DATA, 8'h80, 1'b1, 1'b0, '0},
    '{OP_KEY,  8'h00, 1'b1, 1'b0, '0},
    '{OP_DATA, 8'h01, 1'b1, 1'b0, '0}
  };

  rc4_stream_cipher #(.KEY_MAX(KEY_MAX)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_byte_in   (in_byte_in),
    .in_is_last   (in_is_last),
    .out_strobe   (out_strobe),
    .out_byte_out (out_byte_out),
    .out_out_last (out_out_last),
    .out_status   (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    fail_n++;
    if (fail_n <= 50) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
    end
  endtask

  task automatic rc4_schedule();
    logic [7:0] acc, t;
    int unsigned n;
    n = (key_len == 0) ? 1 : key_len;
    for (int k = 0; k < 256; k++) begin
      sbox[k] = k[7:0];
    end
    acc = 8'h00;
    for (int k = 0; k < 256; k++) begin
      acc = acc + sbox[k] + key_mem[k % n];
      t = sbox[acc];
      sbox[acc] = sbox[k];
      sbox[k] = t;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
    schedules_n++;
  endtask

  task automatic rc4_keystream(output logic [7:0] ks);
    logic [7:0] t, sel;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    t = sbox[idx_j];
    sbox[idx_j] = sbox[idx_i];
    sbox[idx_i] = t;
    sel = sbox[idx_i] + sbox[idx_j];
    ks = sbox[sel];
  endtask

  task automatic rc4_step(input logic op, input logic [7:0] b, input logic last,
                          output bit produced, output cipher_beat_t beat);
    bit flagged;
    logic [7:0] ks;
    produced = 1'b0;
    beat = '0;
    if (op == OP_KEY) begin
      if (key_len < KEY_MAX) begin
        key_mem[key_len] = b;
        key_len++;
      end else begin
        key_dropped = 1'b1;
        dropped_n++;
      end
      if (last) begin
        flagged = key_dropped;
        rc4_schedule();
        key_len = 0;
        have_key = 1'b1;
        key_dropped = 1'b0;
        if (flagged) begin
          long_keys_n++;
          produced = 1'b1;
          beat = '{8'h00, 1'b0, STAT_KEY_LONG};
        end
      end
    end else if (!have_key) begin
      produced = 1'b1;
      beat = '{b, last, STAT_NO_KEY};
    end else begin
      rc4_keystream(ks);
      produced = 1'b1;
      beat = '{b ^ ks, last, STAT_OK};
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic op, input logic [7:0] b, input logic last,
                           input bit typed, input cipher_beat_t typed_beat,
                           input bit no_idle);
    bit produced;
    cipher_beat_t beat;
    int gap;
    start      <= 1'b1;
    in_opcode  <= op;
    in_byte_in <= b;
    in_is_last <= last;
    do @(posedge clk); while (busy);
    accepted_n++;
    rc4_step(op, b, last, produced, beat);
    if (typed) begin
      cipher_q.push_back(typed_beat);
    end else if (produced) begin
      cipher_q.push_back(beat);
    end
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int msg_n);
    int key_n, data_n, r;
    bit no_idle;
    no_idle = ($urandom_range(0, 99) < 30);
    r = $urandom_range(0, 99);
    if (msg_n == 2) key_n = KEY_MAX;
    else if (msg_n == 5) key_n = KEY_MAX + 1 + $urandom_range(0, 7);
    else if (r < 2) key_n = KEY_MAX - $urandom_range(0, 3);
    else if (r < 4) key_n = KEY_MAX + 1 + $urandom_range(0, 3);
    else key_n = $urandom_range(1, 16);
    data_n = $urandom_range(1, 40);
    for (int k = 0; k < key_n; k++) begin
      send_beat(OP_KEY, 8'($urandom_range(0, 255)), k == key_n - 1, 1'b0, '0, no_idle);
    end
    for (int k = 0; k < data_n; k++) begin
      // stray key byte inside a message: starts gathering the next key
      if ($urandom_range(0, 99) < 3) begin
        send_beat(OP_KEY, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0, no_idle);
      end
      send_beat(OP_DATA, 8'($urandom_range(0, 255)), k == data_n - 1, 1'b0, '0, no_idle);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    cipher_beat_t want;
    if (rst_n && out_strobe === 1'b1) begin
      results_n++;
      if (cipher_q.size() == 0) begin
        flag_mismatch("result strobed with nothing expected");
      end else begin
        want = cipher_q.pop_front();
        if (out_byte_out !== want.data)
          flag_mismatch($sformatf("byte_out %02h, expected %02h", out_byte_out, want.data));
        if (out_out_last !== want.last)
          flag_mismatch($sformatf("out_last %b, expected %b", out_out_last, want.last));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end else if (rst_n && out_strobe !== 1'b0) begin
      flag_mismatch("out_strobe unknown");
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               idle_cycles, cipher_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int msg_n;
    for (int k = 0; k < 256; k++) begin
      sbox[k] = k[7:0];
      key_mem[k] = 8'h00;
    end
    key_len     = 0;
    idx_i       = 8'h00;
    idx_j       = 8'h00;
    have_key    = 1'b0;
    key_dropped = 1'b0;
    msg_n       = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].op, dir_rows[k].b, dir_rows[k].last,
                dir_rows[k].typed, dir_rows[k].want, 1'b0);
    end
    drain_results();

    while (accepted_n - dropped_n < ITEMS) begin
      if ($urandom_range(0, 99) < 20) begin
        send_noise();
      end else begin
        send_message(msg_n);
        msg_n++;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    start <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d beats (%0d over-long key bytes dropped), %0d messages,",
             accepted_n, dropped_n, msg_n);
    $display("%0d key schedules (%0d over-long keys) and %0d results scored, %0d mismatches.",
             schedules_n, long_keys_n, results_n, fail_n);
    if (fail_n == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
